>>> rtl/fpa_pkg.sv
`timescale 1ns / 1ps
package fpa_pkg;

  localparam int DEF_FRACTION_BITS = 8;
  localparam int WORD_W = 32;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_LT       = 4'd4,
    OP_GT       = 4'd5,
    OP_GE       = 4'd6,
    OP_LE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_FROM_INT = 4'd14,
    OP_TO_INT   = 4'd15
  } opcode_t;

  // fields that ride alongside the divider
  typedef struct packed {
    logic               is_div;
    logic [WORD_W-1:0]  word;
    logic               cmp;
  } side_t;

endpackage

>>> rtl/fpa_div.sv
`timescale 1ns / 1ps
module fpa_div
  import fpa_pkg::*;
#(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_v,
  input  logic [WORD_W+FRACTION_BITS-1:0]  num,
  input  logic [WORD_W-1:0]                den,
  input  logic                             neg,
  input  logic                             zero,
  input  side_t                            side_in,
  output logic                             out_v,
  output logic [WORD_W-1:0]                quot,
  output logic                             out_neg,
  output logic                             out_zero,
  output side_t                            side_out
);

  localparam int NW = WORD_W + FRACTION_BITS;

  logic              v    [0:NW];
  logic [WORD_W-1:0] r    [0:NW];
  logic [NW-1:0]     nq   [0:NW];
  logic [WORD_W-1:0] d    [0:NW];
  logic              sg   [0:NW];
  logic              zr   [0:NW];
  side_t             sd   [0:NW];

  logic [WORD_W-1:0] r_next  [0:NW-1];
  logic [NW-1:0]     nq_next [0:NW-1];

  assign v[0]  = in_v;
  assign r[0]  = '0;
  assign nq[0] = num;
  assign d[0]  = den;
  assign sg[0] = neg;
  assign zr[0] = zero;
  assign sd[0] = side_in;

  // one restoring quotient bit per stage
  always_comb begin
    logic [WORD_W:0] rs;
    logic            ge;
    for (int k = 0; k < NW; k++) begin
      rs = {r[k], nq[k][NW-1]};
      ge = (rs >= {1'b0, d[k]});
      r_next[k]  = ge ? WORD_W'(rs - {1'b0, d[k]}) : rs[WORD_W-1:0];
      nq_next[k] = {nq[k][NW-2:0], ge};
    end
  end

  for (genvar k = 1; k <= NW; k++) begin : g_stage
    // valid bits
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= v[k-1];
      end
    end

    // payload
    always_ff @(posedge clk) begin
      if (en) begin
        r[k]  <= r_next[k-1];
        nq[k] <= nq_next[k-1];
        d[k]  <= d[k-1];
        sg[k] <= sg[k-1];
        zr[k] <= zr[k-1];
        sd[k] <= sd[k-1];
      end
    end
  end

  assign out_v    = v[NW];
  assign quot     = nq[NW][WORD_W-1:0];
  assign out_neg  = sg[NW];
  assign out_zero = zr[NW];
  assign side_out = sd[NW];

endmodule

>>> rtl/fixed_point_alu_core.sv
`timescale 1ns / 1ps
// channel | signals                                   | dir
// in      | in_valid, in_ready, opcode, operand_a/b   | beat in
// out     | out_valid, out_ready, result_word,        | beat out
//         | compare_true, divide_error                |
// one beat per cycle sustained while out does not stall; 34 + FRACTION_BITS
// register stages: prep, the divider, which resolves one quotient bit per
// stage, and the output register.
// rst clears all valid bits; payload registers are not reset.
// a stall on out freezes the whole pipe and drops in_ready; nothing is lost.
module fixed_point_alu_core
  import fpa_pkg::*;
#(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         opcode,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] result_word,
  output logic               compare_true,
  output logic               divide_error
);

  localparam int NW = WORD_W + FRACTION_BITS;
  localparam logic [63:0] RND = 64'((64'd1 << FRACTION_BITS) - 64'd1);

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // prep stage
  opcode_t            op;
  logic               p_v;
  logic               p_is_mul;
  logic               p_is_div;
  logic [31:0]        p_word;
  logic               p_cmp;
  logic signed [63:0] p_prod;
  logic [NW-1:0]      p_num;
  logic [31:0]        p_den;
  logic               p_neg;
  logic               p_zero;

  logic [31:0] word_c;
  logic        cmp_c;
  logic [31:0] abs_a;
  logic [31:0] abs_b;

  assign op    = opcode_t'(opcode);
  assign abs_a = operand_a[31] ? 32'(-operand_a) : operand_a;
  assign abs_b = operand_b[31] ? 32'(-operand_b) : operand_b;

  // simple ops
  always_comb begin
    logic signed [31:0] tr;
    tr = operand_a + (operand_a[31] ? 32'(RND) : 32'd0);
    word_c = '0;
    cmp_c  = 1'b0;
    case (op)
      OP_ADD:      word_c = operand_a + operand_b;
      OP_SUB:      word_c = operand_a - operand_b;
      OP_LT:       cmp_c  = operand_a < operand_b;
      OP_GT:       cmp_c  = operand_a > operand_b;
      OP_GE:       cmp_c  = operand_a >= operand_b;
      OP_LE:       cmp_c  = operand_a <= operand_b;
      OP_EQ:       cmp_c  = operand_a == operand_b;
      OP_NE:       cmp_c  = operand_a != operand_b;
      OP_MIN:      word_c = (operand_a < operand_b) ? operand_a : operand_b;
      OP_MAX:      word_c = (operand_a > operand_b) ? operand_a : operand_b;
      OP_INC:      word_c = operand_a + 32'sd1;
      OP_DEC:      word_c = operand_a - 32'sd1;
      OP_FROM_INT: word_c = operand_a << FRACTION_BITS;
      OP_TO_INT:   word_c = 32'(tr >>> FRACTION_BITS);
      default:     word_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
    end else if (adv) begin
      p_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_is_mul <= (op == OP_MUL);
      p_is_div <= (op == OP_DIV);
      p_word   <= word_c;
      p_cmp    <= cmp_c;
      p_prod   <= 64'(operand_a) * 64'(operand_b);
      p_num    <= {abs_a, {FRACTION_BITS{1'b0}}};
      p_den    <= abs_b;
      p_neg    <= operand_a[31] ^ operand_b[31];
      p_zero   <= (operand_b == 32'sd0);
    end
  end

  // product scaled down, truncated toward zero
  logic signed [63:0] prod_adj;
  side_t              side_in;
  assign prod_adj = p_prod + (p_prod[63] ? $signed(RND) : 64'sd0);
  assign side_in.is_div = p_is_div;
  assign side_in.word   = p_is_mul ? prod_adj[FRACTION_BITS +: 32] : p_word;
  assign side_in.cmp    = p_cmp;

  logic        d_v;
  logic [31:0] d_q;
  logic        d_neg;
  logic        d_zero;
  side_t       d_side;

  fpa_div #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_v     (p_v),
    .num      (p_num),
    .den      (p_den),
    .neg      (p_neg),
    .zero     (p_zero),
    .side_in  (side_in),
    .out_v    (d_v),
    .quot     (d_q),
    .out_neg  (d_neg),
    .out_zero (d_zero),
    .side_out (d_side)
  );

  // output register with quotient sign fix
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      compare_true <= d_side.cmp;
      divide_error <= d_side.is_div && d_zero;
      if (d_side.is_div) begin
        result_word <= d_zero ? 32'sd0 : (d_neg ? $signed(32'(-d_q)) : $signed(d_q));
      end else begin
        result_word <= d_side.word;
      end
    end
  end

endmodule

>>> verif/alu_result_checker.sv
`timescale 1ns / 1ps
module alu_result_checker
  import fpa_pkg::*;
#(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [3:0]         opcode,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] result_word,
  input  logic               compare_true,
  input  logic               divide_error,
  output int                 fail_count,
  output int                 pending_count,
  output int                 beats_in,
  output int                 beats_out
);

  typedef struct packed {
    logic [31:0] word;
    logic        cmp;
    logic        err;
  } alu_result_t;

  alu_result_t expected_results[$];

  // computes what the alu should return for one operation
  function automatic alu_result_t compute_alu(logic [3:0] op, logic signed [31:0] a,
                                              logic signed [31:0] b);
    alu_result_t r;
    longint sa;
    longint sb;
    longint scale;
    sa = a;
    sb = b;
    scale = longint'(1) << FRACTION_BITS;
    r = '0;
    case (opcode_t'(op))
      OP_ADD: r.word = sa + sb;
      OP_SUB: r.word = sa - sb;
      OP_MUL: r.word = (sa * sb) / scale;
      OP_DIV: begin
        if (sb == 0) r.err = 1'b1;
        else r.word = (sa * scale) / sb;
      end
      OP_LT: r.cmp = sa < sb;
      OP_GT: r.cmp = sa > sb;
      OP_GE: r.cmp = sa >= sb;
      OP_LE: r.cmp = sa <= sb;
      OP_EQ: r.cmp = sa == sb;
      OP_NE: r.cmp = sa != sb;
      OP_MIN: r.word = (sa < sb) ? sa : sb;
      OP_MAX: r.word = (sa > sb) ? sa : sb;
      OP_INC: r.word = sa + 1;
      OP_DEC: r.word = sa - 1;
      OP_FROM_INT: r.word = sa * scale;
      default: r.word = sa / scale;
    endcase
    return r;
  endfunction

  assign pending_count = expected_results.size();

  // predict on input beats, compare on output beats
  always @(posedge clk) begin
    alu_result_t exp_r;
    if (rst) begin
      fail_count <= 0;
      beats_in <= 0;
      beats_out <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(compute_alu(opcode, operand_a, operand_b));
        beats_in <= beats_in + 1;
      end
      if (out_valid && out_ready) begin
        beats_out <= beats_out + 1;
        if (expected_results.size() == 0) begin
          $error("unexpected result beat word=%h", result_word);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (result_word !== exp_r.word || compare_true !== exp_r.cmp ||
              divide_error !== exp_r.err) begin
            fail_count <= fail_count + 1;
            if (result_word !== exp_r.word)
              $error("result_word expected %h actual %h", exp_r.word, result_word);
            if (compare_true !== exp_r.cmp)
              $error("compare_true expected %b actual %b", exp_r.cmp, compare_true);
            if (divide_error !== exp_r.err)
              $error("divide_error expected %b actual %b", exp_r.err, divide_error);
          end
        end
      end
    end
  end

endmodule

>>> verif/tb_fixed_point_alu_core.sv
`timescale 1ns / 1ps
module tb_fixed_point_alu_core;
  import fpa_pkg::*;

  localparam int LATENCY = 34 + DEF_FRACTION_BITS;
  localparam int RANDOM_BEATS = 700;
  localparam int CYCLE_LIMIT = 400000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [3:0]         opcode = '0;
  logic signed [31:0] operand_a = '0;
  logic signed [31:0] operand_b = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] result_word;
  logic               compare_true;
  logic               divide_error;
  int                 fail_count;
  int                 pending_count;
  int                 beats_in;
  int                 beats_out;
  int                 cycle_count = 0;
  bit                 hold_off_done = 1'b0;

  always #5 clk = ~clk;

  fixed_point_alu_core uut (.*);

  alu_result_checker checker_i (.*);

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: one long hold-off once traffic flows; otherwise always ready or random stalls, by beat count
  initial begin
    int hold;
    int mode;
    @(posedge clk);
    while (rst) @(posedge clk);
    while (1) begin
      if (!hold_off_done && beats_in > 40) begin
        out_ready <= 1'b0;
        hold = 0;
        while (hold < 3 * LATENCY) begin
          @(posedge clk);
          hold++;
        end
        hold_off_done = 1'b1;
      end
      mode = (beats_in / 100) % 3;
      if (mode == 0) out_ready <= 1'b1;
      else if (mode == 1) out_ready <= ($urandom_range(0, 3) != 0);
      else out_ready <= ($urandom_range(0, 1) == 1);
      @(posedge clk);
    end
  end

  // hand one beat to the block and wait for acceptance
  task automatic send_beat(input logic [3:0] op, input logic [31:0] a,
                           input logic [31:0] b);
    in_valid <= 1'b1;
    opcode <= op;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // random operand with bias toward edge values and small fixed-point numbers
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000 + $urandom_range(0, 2);
      1: return 32'h7fff_ffff - $urandom_range(0, 2);
      2: return 32'($signed($urandom_range(0, 8)) - 4);
      3: return 32'($signed($urandom_range(0, 4096)) - 2048);
      4: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] edge_vals [6];
    logic [31:0] b;
    int burst;
    int gap;
    int sent;
    edge_vals = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h100};
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: every opcode with extreme operands, zero divisor and ties
    for (int op = 0; op < 16; op++)
      send_beat(4'(op), edge_vals[op % 6], edge_vals[(op + 3) % 6]);
    send_beat(OP_DIV, 32'h0000_1234, 32'h0);
    send_beat(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
    send_beat(OP_MIN, 32'h0000_0300, 32'h0000_0300);
    send_beat(OP_MAX, 32'hffff_ff00, 32'hffff_ff00);
    send_beat(OP_EQ, 32'hdead_beef, 32'hdead_beef);
    send_beat(OP_MUL, 32'h8000_0000, 32'h8000_0000);
    send_beat(OP_TO_INT, 32'hffff_ff01, 32'h0);
    send_beat(OP_INC, 32'h7fff_ffff, 32'h0);
    send_beat(OP_DEC, 32'h8000_0000, 32'h0);

    // random bursts with gaps
    sent = 0;
    while (sent < RANDOM_BEATS) begin
      burst = $urandom_range(1, 30);
      for (int i = 0; i < burst && sent < RANDOM_BEATS; i++) begin
        b = pick_operand();
        if ($urandom_range(0, 15) == 0) b = '0;
        send_beat(4'($urandom_range(0, 15)), pick_operand(), b);
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    // drain
    while (pending_count != 0 || !hold_off_done) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("covered %0d input beats and %0d result beats over all 16 opcodes,",
             beats_in, beats_out);
    $display("including edge operands, zero divisors and a long output stall");
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
